// File: design/mqts_pkg.sv
// Package for the min-queue block: sizes, entry type, stack command and codes.
// Used by mqts_cell, mqts_stack and min_queue_two_stacks.
package mqts_pkg;

  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int DATA_W      = 32;
  // stored value width: the input field is wrapped to this many bits
  localparam int STORE_W     = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef struct packed {
    logic signed [STORE_W-1:0] val;
    logic signed [STORE_W-1:0] rmin;
  } mq_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_cmd_t;

  localparam logic [2:0] K_ENQ   = 3'd0;
  localparam logic [2:0] K_DEQ   = 3'd1;
  localparam logic [2:0] K_FRONT = 3'd2;
  localparam logic [2:0] K_MIN   = 3'd3;
  localparam logic [2:0] K_SIZE  = 3'd4;
  localparam logic [2:0] K_CLEAR = 3'd5;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_DATA = 2'd1;
  localparam logic [1:0] STS_ERR  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_REFILL
  } state_t;

endpackage

// File: design/min_queue_two_stacks.sv
// Top level of the min-queue: two cell-chain stacks, control FSM, output register.
// Depends on mqts_pkg and mqts_stack.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------
//   in      | in_valid, in_stall | kind[2:0], value[31:0] signed
//   out     | out_valid,out_stall| status[1:0], data[31:0] signed
//
// Most requests have their result written to the output register on accept.
// A dequeue or front with an empty pop stack first moves the push stack over,
// one entry per cycle through the cell chains, then loads the result.
// One request is in flight at a time; a new one is taken once the output
// register is empty or being emptied. Reset (rst, synchronous) empties both
// stacks and the output register. A held result holds off the next request.
module min_queue_two_stacks
  import mqts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] data
);

  state_t                    state, state_next;
  stk_cmd_t                  cmd_p, cmd_q;
  logic signed [STORE_W-1:0] val_p, val_q;
  mq_entry_t                 top_p, top_q;
  logic [CNT_W-1:0]          cnt_p, cnt_q, total;
  logic                      pend_pop, pend_pop_next;
  logic                      out_valid_next;
  logic [1:0]                status_next;
  logic signed [31:0]        data_next;
  logic                      load, acc;

  mqts_stack u_push (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_p),
    .push_val (val_p),
    .top      (top_p),
    .cnt      (cnt_p)
  );

  mqts_stack u_pop (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_q),
    .push_val (val_q),
    .top      (top_q),
    .cnt      (cnt_q)
  );

  assign total = cnt_p + cnt_q;

  always_comb begin
    state_next    = state;
    pend_pop_next = pend_pop;
    cmd_p         = '0;
    cmd_q         = '0;
    val_p         = value[STORE_W-1:0];
    val_q         = top_p.val;
    load          = 1'b0;
    status_next   = STS_ERR;
    data_next     = '0;
    in_stall      = (state != ST_IDLE) || (out_valid && out_stall);
    acc           = in_valid && !in_stall;

    case (state)
      ST_IDLE: begin
        if (acc) begin
          load = 1'b1;
          case (kind)
            K_ENQ: begin
              if (total < CNT_W'(DEPTH)) begin
                cmd_p.push  = 1'b1;
                status_next = STS_OK;
              end
            end
            K_DEQ, K_FRONT: begin
              if (total != '0) begin
                if (cnt_q != '0) begin
                  status_next = STS_DATA;
                  data_next   = DATA_W'($signed(top_q.val));
                  cmd_q.pop   = (kind == K_DEQ);
                end else begin
                  // hold the result until the push stack has moved across
                  load          = 1'b0;
                  pend_pop_next = (kind == K_DEQ);
                  state_next    = ST_REFILL;
                end
              end
            end
            K_MIN: begin
              if (total != '0) begin
                status_next = STS_DATA;
                if (cnt_p == '0) begin
                  data_next = DATA_W'($signed(top_q.rmin));
                end else if (cnt_q == '0 || $signed(top_p.rmin) < $signed(top_q.rmin)) begin
                  data_next = DATA_W'($signed(top_p.rmin));
                end else begin
                  data_next = DATA_W'($signed(top_q.rmin));
                end
              end
            end
            K_SIZE: begin
              status_next = STS_DATA;
              data_next   = DATA_W'(total);
            end
            K_CLEAR: begin
              cmd_p.clear = 1'b1;
              cmd_q.clear = 1'b1;
              status_next = STS_OK;
            end
            default: begin
              status_next = STS_ERR;
            end
          endcase
        end
      end
      ST_REFILL: begin
        if (cnt_p != '0) begin
          // advance one entry from the push top onto the pop top
          cmd_p.pop  = 1'b1;
          cmd_q.push = 1'b1;
        end else begin
          load        = 1'b1;
          status_next = STS_DATA;
          data_next   = DATA_W'($signed(top_q.val));
          cmd_q.pop   = pend_pop;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = (out_valid && out_stall) || load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pend_pop  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      pend_pop  <= pend_pop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= status_next;
      data   <= data_next;
    end
  end

`ifndef SYNTH
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cnt_p} + {1'b0, cnt_q}) <= (CNT_W + 1)'(DEPTH))
    else $error("queue holds more than DEPTH entries");

  a_no_result_in_refill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REFILL) |-> !out_valid)
    else $error("result pending while refilling");

  a_refill_moves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REFILL && cnt_p != '0) |=>
      (cnt_q == $past(cnt_q) + CNT_W'(1) && cnt_p == $past(cnt_p) - CNT_W'(1)))
    else $error("refill step did not move one entry");

  a_refill_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && acc && (kind == K_DEQ || kind == K_FRONT) &&
     cnt_q == '0 && cnt_p != '0) |=> (state == ST_REFILL))
    else $error("empty pop stack did not start a refill");
`endif

endmodule

// File: design/mqts_cell.sv
// One stack cell: holds an entry and shifts it toward or away from the top.
// Depends on mqts_pkg.
module mqts_cell
  import mqts_pkg::*;
(
  input  logic      clk,
  input  logic      push,
  input  logic      pop,
  input  mq_entry_t from_up,
  input  mq_entry_t from_dn,
  output mq_entry_t ent
);

  always_ff @(posedge clk) begin
    if (push) begin
      ent <= from_up;
    end else if (pop) begin
      ent <= from_dn;
    end
  end

endmodule

// File: design/mqts_stack.sv
// Stack built as a row of mqts_cell; cell 0 is the top. Keeps the fill count
// and the running minimum of new entries. Depends on mqts_pkg and mqts_cell.
module mqts_stack
  import mqts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  stk_cmd_t                  cmd,
  input  logic signed [STORE_W-1:0] push_val,
  output mq_entry_t                 top,
  output logic [CNT_W-1:0]          cnt
);

  mq_entry_t cells [DEPTH];
  mq_entry_t new_ent;

  // running minimum covers the stack from the bottom up
  always_comb begin
    new_ent.val  = push_val;
    new_ent.rmin = (cnt == '0 || push_val < cells[0].rmin) ? push_val : cells[0].rmin;
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
        mqts_cell u_cell (
          .clk     (clk),
          .push    (cmd.push),
          .pop     (cmd.pop),
          .from_up (new_ent),
          .from_dn (cells[(DEPTH > 1) ? 1 : 0]),
          .ent     (cells[i])
        );
      end else if (i == DEPTH - 1) begin : g_bot
        mqts_cell u_cell (
          .clk     (clk),
          .push    (cmd.push),
          .pop     (cmd.pop),
          .from_up (cells[i-1]),
          .from_dn (cells[i]),
          .ent     (cells[i])
        );
      end else begin : g_mid
        mqts_cell u_cell (
          .clk     (clk),
          .push    (cmd.push),
          .pop     (cmd.pop),
          .from_up (cells[i-1]),
          .from_dn (cells[i+1]),
          .ent     (cells[i])
        );
      end
    end
  endgenerate

  assign top = cells[0];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt <= '0;
    end else if (cmd.push) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

// File: tb/min_queue_two_stacks_tb.sv
// Self-checking testbench for min_queue_two_stacks: drives queue requests, predicts every
// response with its own two-stack model and compares status and data in order.
// Depends on mqts_pkg and the min_queue_two_stacks RTL.
module min_queue_two_stacks_tb
  import mqts_pkg::*;
();

  localparam logic [2:0] K_UNUSED6 = 3'd6;
  localparam logic [2:0] K_UNUSED7 = 3'd7;
  localparam int RANDOM_REQS   = 150;
  localparam int QUIET_TAIL    = 120;
  localparam int STALL_LIMIT   = 6000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] value;
    bit                 drain;
  } mq_req_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] data;
  } mq_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               out_stall = 1'b0;
  logic [2:0]         kind = '0;
  logic signed [31:0] value = '0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         status;
  logic signed [31:0] data;

  min_queue_two_stacks dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data      (data)
  );

  always #6 clk = ~clk;

  // queue model: each entry holds its value and a running minimum
  logic signed [STORE_W-1:0] push_val [DEPTH];
  logic signed [STORE_W-1:0] push_min [DEPTH];
  logic signed [STORE_W-1:0] pop_val  [DEPTH];
  logic signed [STORE_W-1:0] pop_min  [DEPTH];
  int push_n = 0;
  int pop_n  = 0;

  mq_req_t pending[$];
  mq_rsp_t expected_results[$];
  int req_accepted = 0;
  int req_seen     = 0;
  int rsp_errors   = 0;
  int idle_cycles  = 0;
  int in_gap       = 0;
  int stall_gap    = 0;
  int est_size     = 0;

  function automatic logic signed [STORE_W-1:0] lesser(logic signed [STORE_W-1:0] a,
                                                       logic signed [STORE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic mq_rsp_t queue_apply(logic [2:0] k, logic signed [31:0] v);
    mq_rsp_t r;
    logic signed [STORE_W-1:0] x;
    int total;
    r.status = STS_ERR;
    r.data   = '0;
    x        = v[STORE_W-1:0];
    total    = push_n + pop_n;
    case (k)
      K_ENQ: begin
        if (total < DEPTH) begin
          push_val[push_n] = x;
          push_min[push_n] = (push_n == 0) ? x : lesser(x, push_min[push_n-1]);
          push_n++;
          r.status = STS_OK;
        end
      end
      K_DEQ, K_FRONT: begin
        if (total > 0) begin
          // move the push stack across, top first, rebuilding the minima
          if (pop_n == 0) begin
            while (push_n > 0 && pop_n < DEPTH) begin
              push_n--;
              pop_val[pop_n] = push_val[push_n];
              pop_min[pop_n] = (pop_n == 0) ? push_val[push_n]
                                            : lesser(push_val[push_n], pop_min[pop_n-1]);
              pop_n++;
            end
          end
          r.data = pop_val[pop_n-1];
          if (k == K_DEQ) pop_n--;
          r.status = STS_DATA;
        end
      end
      K_MIN: begin
        if (total > 0) begin
          if (push_n == 0)     r.data = pop_min[pop_n-1];
          else if (pop_n == 0) r.data = push_min[push_n-1];
          else                 r.data = lesser(push_min[push_n-1], pop_min[pop_n-1]);
          r.status = STS_DATA;
        end
      end
      K_SIZE: begin
        r.data   = total;
        r.status = STS_DATA;
      end
      K_CLEAR: begin
        push_n   = 0;
        pop_n    = 0;
        r.status = STS_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      // small values make ties among minima likely
      1, 2, 3: return int'($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic [2:0] k, logic signed [31:0] v, bit drain);
    mq_req_t r;
    r.kind  = k;
    r.value = v;
    r.drain = drain;
    pending.push_back(r);
    case (k)
      K_ENQ:   if (est_size < DEPTH) est_size++;
      K_DEQ:   if (est_size > 0) est_size--;
      K_CLEAR: est_size = 0;
      default: ;
    endcase
  endtask

  // request driver: changes inputs on the falling edge
  always @(negedge clk) begin
    mq_req_t nxt;
    bit taken;
    taken    = (req_accepted != req_seen);
    req_seen = req_accepted;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending[0].drain && expected_results.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else begin
        nxt = pending.pop_front();
        kind     <= nxt.kind;
        value    <= nxt.value;
        in_valid <= 1'b1;
      end
    end
  end

  // response back-pressure in random bursts
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_gap > 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else if (pending.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
      stall_gap = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on request accept, compare on response accept
  always @(posedge clk) begin
    mq_rsp_t want;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(queue_apply(kind, value));
        req_accepted++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          rsp_errors++;
          if (rsp_errors <= MAX_REPORTS)
            $display("unexpected response: status %0d data %0d", status, data);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status || data !== want.data) begin
            rsp_errors++;
            if (rsp_errors <= MAX_REPORTS)
              $display("response mismatch: status exp %0d got %0d, data exp %0d got %0d",
                       want.status, status, want.data, data);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int n_reqs;
    int r;
    int enq_w;
    logic [2:0] k;

    // directed: empty-queue errors, unknown kinds, extremes, refill, clear
    add_req(K_SIZE,    pick_value(), 1'b0);
    add_req(K_DEQ,     pick_value(), 1'b0);
    add_req(K_FRONT,   pick_value(), 1'b0);
    add_req(K_MIN,     pick_value(), 1'b0);
    add_req(K_UNUSED6, pick_value(), 1'b0);
    add_req(K_UNUSED7, pick_value(), 1'b0);
    add_req(K_ENQ,     32'sh7FFF_FFFF, 1'b0);
    add_req(K_ENQ,     32'sh8000_0000, 1'b0);
    add_req(K_ENQ,     32'sh0000_0000, 1'b0);
    add_req(K_ENQ,     -32'sd1, 1'b0);
    add_req(K_MIN,     pick_value(), 1'b0);
    add_req(K_FRONT,   pick_value(), 1'b0);
    add_req(K_ENQ,     32'sd5, 1'b0);
    add_req(K_MIN,     pick_value(), 1'b0);
    add_req(K_DEQ,     pick_value(), 1'b0);
    add_req(K_DEQ,     pick_value(), 1'b0);
    add_req(K_SIZE,    pick_value(), 1'b0);
    add_req(K_CLEAR,   pick_value(), 1'b0);
    add_req(K_SIZE,    pick_value(), 1'b0);
    add_req(K_DEQ,     pick_value(), 1'b0);
    add_req(K_ENQ,     32'sh5555_5555, 1'b0);
    add_req(K_ENQ,     32'shAAAA_AAAA, 1'b0);
    add_req(K_DEQ,     pick_value(), 1'b0);
    add_req(K_MIN,     pick_value(), 1'b0);
    add_req(K_CLEAR,   pick_value(), 1'b0);

    // fill to capacity, overflow, then refill the whole pop stack at once
    add_req(K_CLEAR, pick_value(), 1'b1);
    for (int i = 0; i < DEPTH + 2; i++) add_req(K_ENQ, pick_value(), 1'b0);
    add_req(K_SIZE,  pick_value(), 1'b0);
    add_req(K_MIN,   pick_value(), 1'b0);
    add_req(K_FRONT, pick_value(), 1'b0);
    for (int i = 0; i < 3; i++) add_req(K_DEQ, pick_value(), 1'b0);
    add_req(K_ENQ,   pick_value(), 1'b0);
    add_req(K_ENQ,   pick_value(), 1'b0);
    add_req(K_MIN,   pick_value(), 1'b0);
    add_req(K_SIZE,  pick_value(), 1'b0);
    add_req(K_ENQ,   pick_value(), 1'b0);
    add_req(K_ENQ,   pick_value(), 1'b0);
    add_req(K_CLEAR, pick_value(), 1'b0);

    // random mix, biased to keep the queue moderately filled
    for (int i = 0; i < RANDOM_REQS; i++) begin
      r     = $urandom_range(0, 99);
      enq_w = (est_size < 4) ? 55 : (est_size > 48) ? 25 : 40;
      if (r < enq_w)            k = K_ENQ;
      else if (r < enq_w + 20)  k = K_DEQ;
      else if (r < enq_w + 27)  k = K_FRONT;
      else if (r < enq_w + 37)  k = K_MIN;
      else if (r < enq_w + 42)  k = K_SIZE;
      else if (r < enq_w + 43)  k = K_CLEAR;
      else if (r < enq_w + 45)  k = $urandom_range(0, 1) ? K_UNUSED6 : K_UNUSED7;
      else                      k = K_DEQ;
      add_req(k, pick_value(), (i % 75) == 74);
    end
    n_reqs = pending.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_accepted < n_reqs) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (rsp_errors == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
